[design/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// screen geometry defaults
	localparam int TCW_COLUMNS = 80;
	localparam int TCW_ROWS    = 25;

	// fixed field widths
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int IDX_W     = 11;
	localparam int CELL_W    = 16;
	localparam int TAB_STEP  = 8;

	// request function codes
	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// character codes
	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7F;

	// white on black space
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	typedef struct packed {
		logic             func;
		logic [7:0]       char_code;
		logic [3:0]       bg_attr;
		logic [3:0]       fg_attr;
		logic [IDX_W-1:0] read_index;
	} tcw_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  cursor_index;
		logic [CELL_W-1:0] cell_data;
		logic              scrolled;
	} tcw_rsp_t;

endpackage

`default_nettype wire

[design/tcw_stream_if.sv]
// ----------------------------------------------------------------------------
// tcw_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// text mode console engine over a ROWS x COLUMNS screen of 16-bit cells
// ----------------------------------------------------------------------------
// A put beat interprets one character at the cursor (printable codes are
// stored with their attribute, backspace, tab, carriage return and line feed
// move the cursor, everything else is ignored); a read beat returns one cell.
// Every request produces exactly one response beat carrying the linear cursor
// index for the crt controller. The screen lives in a single ram with one
// write and one registered read port, and all timing follows from that port:
// a put or read goes from accept through execute and finish to the next
// accept, plus any wait for the response register to drain. A put that moves
// past the last row scrolls: the ram is copied one cell a cycle and the bottom
// row is blanked. After reset the whole screen is cleared to blank cells in
// one pass during which req.ready stays low. The block handles one request at
// a time; a finished response may sit in the output register while the next
// request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input logic          clk,
	input logic          arst_n,
	tcw_stream_if.sink   req,
	tcw_stream_if.source rsp
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CN_W  = COL_W + 1;

	localparam logic [AW-1:0]    COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);
	localparam logic [AW-1:0]    CELL_LAST = AW'(CELLS - 1);
	localparam logic [AW-1:0]    ROW_STEP  = AW'(COLUMNS);
	localparam logic [CN_W-1:0]  COL_LIMIT = CN_W'(COLUMNS);
	localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROWS);
	localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);

	// sequencer states
	localparam logic [2:0] ST_FILL   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_COPY   = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]       state_q;
	logic [AW-1:0]    cnt_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             scrolled_q;
	logic             rd_hit_q;
	logic             rsp_valid_q;
	logic             copy_s1;
	logic [AW-1:0]    dst_s1;
	tcw_req_t         req_q;
	tcw_rsp_t         rsp_data_q;

	// shared index unit: row * COLUMNS + col
	logic [AW-1:0] lin;

	logic [CN_W-1:0]  col_ext;
	logic [CN_W-1:0]  col_nx;
	logic [ROW_W-1:0] row_nx;
	logic             row_inc;
	logic             wr_char;
	logic             do_scroll;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic [AW-1:0]     raddr;
	logic [CELL_W-1:0] rdata;
	logic              rsp_load;

	assign lin = AW'(row_q) * ROW_STEP + AW'(col_q);

	// cursor movement for the current put
	always_comb begin
		col_ext   = {1'b0, col_q};
		col_nx    = col_ext;
		row_inc   = 1'b0;
		wr_char   = 1'b0;
		case (req_q.char_code)
			CH_BS: begin
				if (col_q != '0) begin
					col_nx = col_ext - CN_W'(1);
				end
			end
			CH_TAB: begin
				// next tab stop
				col_nx = (col_ext + CN_W'(TAB_STEP)) & ~CN_W'(TAB_STEP - 1);
			end
			CH_CR: begin
				col_nx = '0;
			end
			CH_LF: begin
				col_nx  = '0;
				row_inc = 1'b1;
			end
			default: begin
				if (req_q.char_code >= CH_PRINT_LO && req_q.char_code <= CH_PRINT_HI) begin
					wr_char = 1'b1;
					col_nx  = col_ext + CN_W'(1);
				end
			end
		endcase
		// wrap at the right edge
		if (col_nx >= COL_LIMIT) begin
			col_nx  = '0;
			row_inc = 1'b1;
		end
		row_nx    = row_q + ROW_W'(row_inc);
		do_scroll = (row_nx == ROW_LIMIT);
		if (do_scroll) begin
			row_nx = ROW_LAST;
		end
	end

	// ram write port: copy beat, blank fill, or character store
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = BLANK_CELL;
		if (copy_s1) begin
			we    = 1'b1;
			waddr = dst_s1;
			wdata = rdata;
		end else if (state_q == ST_FILL) begin
			we = 1'b1;
		end else if (state_q == ST_EXEC && req_q.func == FUNC_PUT && wr_char) begin
			we    = 1'b1;
			waddr = lin;
			wdata = {req_q.bg_attr, req_q.fg_attr, req_q.char_code};
		end
	end

	// copy reads one row ahead; otherwise hold the read address of the request
	assign raddr = (state_q == ST_COPY) ? cnt_q + ROW_STEP : AW'(req_q.read_index);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_tcw_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rsp_load  = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			scrolled_q  <= 1'b0;
			rd_hit_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			copy_s1     <= 1'b0;
		end else begin
			copy_s1 <= (state_q == ST_COPY);
			// a new beat loads as the old one leaves
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_FILL: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == CELL_LAST) begin
						state_q <= scrolled_q ? ST_FINISH : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					rd_hit_q <= (int'(req_q.read_index) < CELLS);
					if (req_q.func == FUNC_PUT) begin
						col_q      <= col_nx[COL_W-1:0];
						row_q      <= row_nx;
						scrolled_q <= do_scroll;
						if (do_scroll) begin
							cnt_q   <= '0;
							state_q <= ST_COPY;
						end else begin
							state_q <= ST_FINISH;
						end
					end else begin
						scrolled_q <= 1'b0;
						state_q    <= ST_FINISH;
					end
				end
				ST_COPY: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == COPY_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last copy beat lands, then the bottom row is blanked
					state_q <= ST_FILL;
				end
				ST_FINISH: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.data;
		end
		dst_s1 <= cnt_q;
		if (rsp_load) begin
			rsp_data_q.cursor_index <= IDX_W'(lin);
			rsp_data_q.cell_data    <= (req_q.func == FUNC_READ && rd_hit_q) ? rdata : '0;
			rsp_data_q.scrolled     <= scrolled_q;
		end
	end

endmodule

`default_nettype wire

[design/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram
	import tcw_pkg::*;
#(
	parameter int WIDTH = CELL_W,
	parameter int DEPTH = TCW_ROWS * TCW_COLUMNS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[design/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker
// port level checks of the text console writer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input tcw_rsp_t rsp_data
);

	// stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> int'(rsp_data.cursor_index) < ROWS * COLUMNS)
		else $error("cursor index off screen");

	// a scroll leaves the cursor on the bottom row
	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.scrolled |-> int'(rsp_data.cursor_index) >= (ROWS - 1) * COLUMNS)
		else $error("scroll left cursor above bottom row");

	// only reads return cell data, and reads never scroll
	a_read_no_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.cell_data != '0 |-> !rsp_data.scrolled)
		else $error("cell data on a scrolling put");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
